>>> rtl/lerq_pkg.sv
package lerq_pkg;

  localparam int LIST_CAPACITY_DEF = 32;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_GET    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_UNUSED = 2'd3;

  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] cyl;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [15:0] cyl;
    logic [15:0] tag;
  } res_t;

endpackage

>>> rtl/lerq_ram.sv
module lerq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = lerq_pkg::LIST_CAPACITY_DEF
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/look_elevator_request_queue.sv
// LOOK elevator request queue: a downward list (descending cylinders) and an upward list
// (ascending) are each held in a dual-port RAM, with the head entry of each list mirrored in
// registers. Get, an unknown command and any request that needs no list movement go straight
// to the done state, which loads the output register once it is free. A sorted insert walks
// the target list from its tail, one entry per cycle through the RAM; a remove shifts the
// list towards its head one entry per cycle. One request is in progress at a time; a finished
// result waits in the output register while the next request is taken.
module look_elevator_request_queue #(
  parameter int LIST_CAPACITY = lerq_pkg::LIST_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command[1:0], cylinder[17:2], request_tag[33:18], zero pad
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], found[2], next_cylinder[18:3], next_tag[34:19], pending_count[41:35],
  // direction[42], zero pad
  output logic [47:0] out_tdata
);
  localparam int IW = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
  localparam int CW = $clog2(LIST_CAPACITY + 1);

  typedef logic [CW-1:0] cnt_t;
  typedef logic [IW-1:0] idx_t;
  localparam cnt_t CAP_C = cnt_t'(LIST_CAPACITY);

  typedef enum logic [2:0] {S_IDLE, S_INS, S_INS0, S_POP, S_DONE} state_t;

  state_t            state_r, state_nxt;
  logic              dir_r, dir_nxt;
  cnt_t              cnt_r [2];
  cnt_t              cnt_nxt [2];
  lerq_pkg::entry_t  head_r [2];
  lerq_pkg::entry_t  head_nxt [2];
  lerq_pkg::entry_t  new_r, new_nxt;
  logic              tgt_r, tgt_nxt;
  idx_t              pos_r, pos_nxt;
  lerq_pkg::res_t    res_r, res_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [47:0]       out_tdata_r, out_tdata_nxt;

  logic              we;
  logic              wl;
  idx_t              waddr, raddr;
  lerq_pkg::entry_t  wdata;
  lerq_pkg::entry_t  rdata [2];

  logic [1:0]        cmd;
  lerq_pkg::entry_t  req;
  logic [CW:0]       total;

  assign cmd     = in_tdata[1:0];
  assign req.cyl = in_tdata[17:2];
  assign req.tag = in_tdata[33:18];
  assign total   = {1'b0, cnt_r[0]} + {1'b0, cnt_r[1]};

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  for (genvar l = 0; l < 2; l++) begin : g_list
    lerq_ram #(.WIDTH(32), .DEPTH(LIST_CAPACITY)) u_ram (
      .clk   (clk),
      .we    (we && (wl == 1'(l))),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata[l])
    );
  end

  always_comb begin
    logic             d;
    logic             t;
    logic             after;
    lerq_pkg::entry_t r;
    state_nxt      = state_r;
    dir_nxt        = dir_r;
    cnt_nxt        = cnt_r;
    head_nxt       = head_r;
    new_nxt        = new_r;
    tgt_nxt        = tgt_r;
    pos_nxt        = pos_r;
    res_nxt        = res_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    we             = 1'b0;
    wl             = tgt_r;
    waddr          = '0;
    wdata          = new_r;
    raddr          = '0;
    d              = dir_r;
    t              = dir_r;
    r              = rdata[tgt_r];
    after          = tgt_r ? (new_r.cyl < r.cyl) : (new_r.cyl > r.cyl);
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_nxt   = '0;
          state_nxt = S_DONE;
          d = dir_r ^ (cnt_r[dir_r] == '0);
          case (cmd)
            lerq_pkg::CMD_INSERT: begin
              dir_nxt = d;
              if (cnt_r[d] == '0) begin
                t = d;
              end else if (req.cyl < head_r[d].cyl) begin
                t = 1'b0;
              end else if (req.cyl > head_r[d].cyl) begin
                t = 1'b1;
              end else begin
                t = d;
              end
              new_nxt = req;
              tgt_nxt = t;
              if (cnt_r[t] >= CAP_C) begin
                res_nxt.status = lerq_pkg::ST_FULL;
              end else if (cnt_r[t] == '0) begin
                we          = 1'b1;
                wl          = t;
                wdata       = req;
                head_nxt[t] = req;
                cnt_nxt[t]  = cnt_t'(1);
              end else begin
                pos_nxt   = idx_t'(cnt_r[t] - cnt_t'(1));
                raddr     = idx_t'(cnt_r[t] - cnt_t'(1));
                state_nxt = S_INS;
              end
            end
            lerq_pkg::CMD_GET: begin
              dir_nxt = d;
              if (cnt_r[d] != '0) begin
                res_nxt.found = 1'b1;
                res_nxt.cyl   = head_r[d].cyl;
                res_nxt.tag   = head_r[d].tag;
              end
            end
            lerq_pkg::CMD_REMOVE: begin
              tgt_nxt = dir_r;
              if (cnt_r[dir_r] == '0) begin
                res_nxt.status = lerq_pkg::ST_EMPTY;
              end else if (cnt_r[dir_r] == cnt_t'(1)) begin
                cnt_nxt[dir_r] = '0;
              end else begin
                pos_nxt   = idx_t'(1);
                raddr     = idx_t'(1);
                state_nxt = S_POP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_INS: begin
        we    = 1'b1;
        waddr = pos_r + idx_t'(1);
        if (after) begin
          wdata = r;
          if (pos_r == '0) begin
            state_nxt = S_INS0;
          end else begin
            pos_nxt = pos_r - idx_t'(1);
            raddr   = pos_r - idx_t'(1);
          end
        end else begin
          wdata           = new_r;
          cnt_nxt[tgt_r]  = cnt_r[tgt_r] + cnt_t'(1);
          state_nxt       = S_DONE;
        end
      end
      S_INS0: begin
        we              = 1'b1;
        waddr           = '0;
        wdata           = new_r;
        head_nxt[tgt_r] = new_r;
        cnt_nxt[tgt_r]  = cnt_r[tgt_r] + cnt_t'(1);
        state_nxt       = S_DONE;
      end
      S_POP: begin
        we    = 1'b1;
        waddr = pos_r - idx_t'(1);
        wdata = r;
        if (pos_r == idx_t'(1)) begin
          head_nxt[tgt_r] = r;
        end
        if (cnt_t'(pos_r) == cnt_r[tgt_r] - cnt_t'(1)) begin
          cnt_nxt[tgt_r] = cnt_r[tgt_r] - cnt_t'(1);
          state_nxt      = S_DONE;
        end else begin
          pos_nxt = pos_r + idx_t'(1);
          raddr   = pos_r + idx_t'(1);
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {5'b0, dir_r, 7'(total), res_r.tag, res_r.cyl,
                            res_r.found, res_r.status};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      dir_r        <= 1'b0;
      cnt_r[0]     <= '0;
      cnt_r[1]     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      dir_r        <= dir_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r      <= head_nxt;
    new_r       <= new_nxt;
    tgt_r       <= tgt_nxt;
    pos_r       <= pos_nxt;
    res_r       <= res_nxt;
    out_tdata_r <= out_tdata_nxt;
  end
endmodule

>>> rtl/lerq_checker.sv
module lerq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) $past(!rst_n) |-> !out_tvalid)
    else $error("result valid straight after reset");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != lerq_pkg::ST_UNUSED)
    else $error("undefined status code");

  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1:0] == lerq_pkg::ST_OK)
    else $error("found request with error status");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken before the first finished");
endmodule

bind look_elevator_request_queue lerq_checker u_lerq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
